@@ rtl/otp_page_controller_unit_assert.svh @@
// Assertion macros shared by the checker files.
// Each macro expects a signal named clock in the enclosing scope; OPC_ASSERT also expects reset.
`ifndef OTP_PAGE_CONTROLLER_UNIT_ASSERT_SVH
`define OTP_PAGE_CONTROLLER_UNIT_ASSERT_SVH

// Checked outside reset only.
`define OPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset cycles included.
`define OPC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/opc_pkg.sv @@
// ----------------------------------------------------------------------------
// opc_pkg
// Shared constants, register map, microcode program and control types for
// the OTP page controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package opc_pkg;

   localparam int PAGE_COUNT     = 512;
   localparam int WORDS_PER_PAGE = 4;
   localparam int STORE_WORDS    = PAGE_COUNT * WORDS_PER_PAGE;
   localparam int STORE_AW       = $clog2(STORE_WORDS);
   localparam int WORD_IW        = $clog2(WORDS_PER_PAGE);

   localparam int DATA_W   = 32;
   localparam int OFFSET_W = 6;
   localparam int PAGE_W   = 9;
   localparam int BE_W     = 16;
   localparam int STEP_W   = 3;
   localparam int PROG_LEN = 2 ** STEP_W;

   // register map, word offsets
   localparam logic [OFFSET_W-1:0] REG_CONTROL = 6'd0;
   localparam logic [OFFSET_W-1:0] REG_BYTE_EN = 6'd1;
   localparam logic [OFFSET_W-1:0] REG_STATUS  = 6'd2;
   localparam logic [OFFSET_W-1:0] REG_TIMING  = 6'd3;
   localparam logic [OFFSET_W-1:0] REG_DATA0   = 6'd32;
   localparam logic [OFFSET_W-1:0] REG_DATA1   = 6'd33;
   localparam logic [OFFSET_W-1:0] REG_DATA2   = 6'd34;
   localparam logic [OFFSET_W-1:0] REG_DATA3   = 6'd35;

   localparam int CTL_READ_BIT  = 14;
   localparam int CTL_WRITE_BIT = 15;

   localparam logic [BE_W-1:0]   BE_RESET     = 16'hFFFF;
   localparam logic [DATA_W-1:0] TIMING_RESET = 32'h0000_1485;

   // one microcode word
   typedef struct packed {
      logic               rd_en;
      logic [WORD_IW-1:0] rd_word;
      logic               mg_en;
      logic [WORD_IW-1:0] mg_word;
      logic               skip_jmp;
      logic [STEP_W-1:0]  target;
      logic               finish;
   } opc_uop_type;

   // sequencer to datapath control
   typedef struct packed {
      logic               busy;
      logic               rd_en;
      logic [WORD_IW-1:0] rd_word;
      logic               mg_en;
      logic [WORD_IW-1:0] mg_word;
      logic               finish;
   } opc_ctrl_type;

   localparam logic [STEP_W-1:0] STEP_FINISH = 3'd5;

   // read of word n overlaps the merge of word n-1 (registered read data)
   localparam opc_uop_type PROGRAM [PROG_LEN] = '{
      '{1'b1, 2'd0, 1'b0, 2'd0, 1'b1, STEP_FINISH, 1'b0},
      '{1'b1, 2'd1, 1'b1, 2'd0, 1'b0, 3'd0,        1'b0},
      '{1'b1, 2'd2, 1'b1, 2'd1, 1'b0, 3'd0,        1'b0},
      '{1'b1, 2'd3, 1'b1, 2'd2, 1'b0, 3'd0,        1'b0},
      '{1'b0, 2'd0, 1'b1, 2'd3, 1'b0, 3'd0,        1'b0},
      '{1'b0, 2'd0, 1'b0, 2'd0, 1'b0, 3'd0,        1'b1},
      '{1'b0, 2'd0, 1'b0, 2'd0, 1'b0, 3'd0,        1'b1},
      '{1'b0, 2'd0, 1'b0, 2'd0, 1'b0, 3'd0,        1'b1}
   };

   // bytes with enable set come from upd, the rest from base
   function automatic logic [DATA_W-1:0] byte_merge(
      input logic [DATA_W-1:0] base,
      input logic [DATA_W-1:0] upd,
      input logic [3:0]        be
   );
      logic [DATA_W-1:0] res;
      res = base;
      for (int b = 0; b < 4; b++) begin
         if (be[b]) begin
            res[8*b +: 8] = upd[8*b +: 8];
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ rtl/opc_page_ram.sv @@
// ----------------------------------------------------------------------------
// opc_page_ram
// Page store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opc_page_ram
   import opc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [STORE_AW-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]   wr_data,
   input  wire logic                rd_en,
   input  wire logic [STORE_AW-1:0] rd_addr,
   output logic      [DATA_W-1:0]   rd_data
);

   logic [DATA_W-1:0] mem [STORE_WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/opc_sequencer.sv @@
// ----------------------------------------------------------------------------
// opc_sequencer
// Microcode sequencer: step counter over the transfer program, with a
// conditional jump that skips the page access for an out-of-range page.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module opc_sequencer
   import opc_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   start,
   input  wire logic   skip,
   output opc_ctrl_type ctrl
);

   logic              active_ff, active_in;
   logic [STEP_W-1:0] step_ff, step_in;
   opc_uop_type       uop;

   always_comb begin
      uop = PROGRAM[step_ff];

      ctrl.busy    = active_ff;
      ctrl.rd_en   = active_ff & uop.rd_en;
      ctrl.rd_word = uop.rd_word;
      ctrl.mg_en   = active_ff & uop.mg_en;
      ctrl.mg_word = uop.mg_word;
      ctrl.finish  = active_ff & uop.finish;

      active_in = active_ff;
      step_in   = step_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
      end else if (active_ff) begin
         if (uop.finish) begin
            active_in = 1'b0;
         end else if (uop.skip_jmp && skip) begin
            step_in = uop.target;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= '0;
      end else begin
         active_ff <= active_in;
         step_ff   <= step_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/otp_page_controller_unit.sv @@
// ----------------------------------------------------------------------------
// otp_page_controller_unit
// Register-mapped OTP page store with microcoded page transfer.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one 32-bit register transaction (req_func 1 = write).
//   rsp_* returns one transaction per request: register value on reads,
//   zero on writes. Both channels use valid/stall; a transaction moves when
//   valid is high and stall is low.
//   Plain register accesses respond the cycle after acceptance and can be
//   taken every cycle while no response is held by rsp_stall.
//   A write to control runs the transfer program over the four store words
//   (read and merge overlapped) and responds when it finishes; a page that
//   is out of range skips the store access. The transfer is paced by the
//   microcode step counter over the single store read port.
//   One transaction is in flight at a time; req_stall stays high while a
//   transfer runs or while a response is held by rsp_stall.
//   After reset the page store is cleared one word per cycle, all STORE_WORDS
//   (2048) words, with req_stall high throughout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module otp_page_controller_unit
   import opc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_func,
   input  wire logic [OFFSET_W-1:0] req_word_offset,
   input  wire logic [DATA_W-1:0]   req_write_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [DATA_W-1:0]   rsp_read_data
);

   opc_ctrl_type ctrl;

   logic                accept, start, skip;
   logic                clearing_ff, clearing_in;
   logic [STORE_AW-1:0] clr_addr_ff, clr_addr_in;

   logic [PAGE_W-1:0]   page_ff, page_in;
   logic                read_ff, read_in;
   logic                write_ff, write_in;
   logic                done_ff, done_in;
   logic [BE_W-1:0]     be_ff, be_in;
   logic [DATA_W-1:0]   timing_ff, timing_in;
   logic [DATA_W-1:0]   data_ff [WORDS_PER_PAGE];
   logic [DATA_W-1:0]   data_in [WORDS_PER_PAGE];

   logic                rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [DATA_W-1:0]   reg_rd_val;

   logic                ram_wr_en;
   logic [STORE_AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [DATA_W-1:0]   ram_wr_data, ram_rd_data;
   logic [DATA_W-1:0]   mg_data_word, new_page_word, new_data_word;
   logic [3:0]          mg_be;

   assign req_stall = clearing_ff | ctrl.busy | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign start     = accept & req_func & (req_word_offset == REG_CONTROL);
   assign skip      = ({1'b0, page_ff} >= (PAGE_W+1)'(PAGE_COUNT));

   opc_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .start (start),
      .skip  (skip),
      .ctrl  (ctrl)
   );

   // transfer datapath: page word written first, then data word from it
   always_comb begin
      mg_data_word  = data_ff[ctrl.mg_word];
      mg_be         = be_ff[{ctrl.mg_word, 2'b00} +: 4];
      new_page_word = write_ff ? byte_merge(ram_rd_data, mg_data_word, mg_be)
                               : ram_rd_data;
      new_data_word = read_ff ? byte_merge(mg_data_word, new_page_word, mg_be)
                              : mg_data_word;
   end

   assign ram_rd_addr = STORE_AW'({page_ff, ctrl.rd_word});
   assign ram_wr_en   = clearing_ff | (ctrl.mg_en & write_ff);
   assign ram_wr_addr = clearing_ff ? clr_addr_ff
                                    : STORE_AW'({page_ff, ctrl.mg_word});
   assign ram_wr_data = clearing_ff ? '0 : new_page_word;

   opc_page_ram u_page_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ctrl.rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      case (req_word_offset)
         REG_CONTROL: reg_rd_val = {16'b0, write_ff, read_ff, 5'b0, page_ff};
         REG_BYTE_EN: reg_rd_val = {16'b0, be_ff};
         REG_STATUS:  reg_rd_val = {31'b0, done_ff};
         REG_TIMING:  reg_rd_val = timing_ff;
         REG_DATA0:   reg_rd_val = data_ff[0];
         REG_DATA1:   reg_rd_val = data_ff[1];
         REG_DATA2:   reg_rd_val = data_ff[2];
         REG_DATA3:   reg_rd_val = data_ff[3];
         default:     reg_rd_val = '0;
      endcase
   end

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      page_in     = page_ff;
      read_in     = read_ff;
      write_in    = write_ff;
      done_in     = done_ff;
      be_in       = be_ff;
      timing_in   = timing_ff;
      data_in     = data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == STORE_AW'(STORE_WORDS - 1)) begin
            clearing_in = 1'b0;
         end
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (accept && req_func) begin
         case (req_word_offset)
            REG_CONTROL: begin
               page_in  = req_write_data[PAGE_W-1:0];
               read_in  = req_write_data[CTL_READ_BIT];
               write_in = req_write_data[CTL_WRITE_BIT];
            end
            REG_BYTE_EN: be_in = req_write_data[BE_W-1:0];
            REG_STATUS: begin
               if (req_write_data[0]) begin
                  done_in = 1'b0;
               end
            end
            REG_TIMING: timing_in  = req_write_data;
            REG_DATA0:  data_in[0] = req_write_data;
            REG_DATA1:  data_in[1] = req_write_data;
            REG_DATA2:  data_in[2] = req_write_data;
            REG_DATA3:  data_in[3] = req_write_data;
            default: ;
         endcase
      end

      // control writes answer at the end of the program
      if (accept && !start) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = req_func ? '0 : reg_rd_val;
      end

      if (ctrl.mg_en) begin
         data_in[ctrl.mg_word] = new_data_word;
      end

      if (ctrl.finish) begin
         done_in      = 1'b1;
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         page_ff      <= '0;
         read_ff      <= 1'b0;
         write_ff     <= 1'b0;
         done_ff      <= 1'b0;
         be_ff        <= BE_RESET;
         timing_ff    <= TIMING_RESET;
         data_ff      <= '{default: '0};
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         page_ff      <= page_in;
         read_ff      <= read_in;
         write_ff     <= write_in;
         done_ff      <= done_in;
         be_ff        <= be_in;
         timing_ff    <= timing_in;
         data_ff      <= data_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

`default_nettype wire

@@ rtl/opc_checker.sv @@
// ----------------------------------------------------------------------------
// opc_checker
// Port-level checks for the OTP page controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "otp_page_controller_unit_assert.svh"

module opc_checker
   import opc_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                req_func,
   input wire logic [OFFSET_W-1:0] req_word_offset,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [DATA_W-1:0]   rsp_read_data
);

   logic req_fire, rsp_hold, reg_write;

   assign req_fire  = req_valid & ~req_stall;
   assign rsp_hold  = rsp_valid & rsp_stall;
   assign reg_write = req_fire & req_func & (req_word_offset != REG_CONTROL);

   // no response out of reset
   `OPC_ASSERT_ALWAYS(a_reset_no_rsp, reset |=> !rsp_valid, "response valid after reset")

   // store clear holds off requests right after reset
   `OPC_ASSERT_ALWAYS(a_reset_stall, reset |=> req_stall, "request taken during store clear")

   `OPC_ASSERT(a_rsp_hold, rsp_hold |=> rsp_valid && $stable(rsp_read_data), "held rsp changed")

   // single response slot: no new transaction while one is held
   `OPC_ASSERT(a_one_in_flight, rsp_hold |-> !req_fire, "transaction taken while rsp held")

   // plain register writes answer zero on the next cycle
   `OPC_ASSERT(a_write_ack, reg_write |=> rsp_valid && (rsp_read_data == '0), "bad write answer")

endmodule

bind otp_page_controller_unit opc_checker u_opc_checker (.*);

`default_nettype wire

@@ tb/otp_page_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otp_page_checker
// Watches the request and response channels of the OTP page controller,
// keeps a shadow copy of its registers and page store, predicts the read
// data of every accepted request and compares it with the responses in
// order. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------

module otp_page_checker
   import opc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_stall,
   input  wire logic                req_func,
   input  wire logic [OFFSET_W-1:0] req_word_offset,
   input  wire logic [DATA_W-1:0]   req_write_data,
   input  wire logic                rsp_valid,
   input  wire logic                rsp_stall,
   input  wire logic [DATA_W-1:0]   rsp_read_data,
   output int                       error_count,
   output int                       pending
);

   localparam int PRINT_LIMIT = 100;

   logic [DATA_W-1:0] shadow_pages [STORE_WORDS];
   logic [DATA_W-1:0] shadow_data  [WORDS_PER_PAGE];
   logic [BE_W-1:0]   shadow_byte_en;
   logic [DATA_W-1:0] shadow_timing;
   logic [PAGE_W-1:0] shadow_page;
   logic              shadow_rd_flag;
   logic              shadow_wr_flag;
   logic              shadow_done;

   logic [DATA_W-1:0] expected_read_data [$];
   int                requests_seen  = 0;
   int                responses_seen = 0;
   int                mismatches     = 0;

   assign pending     = requests_seen - responses_seen;
   assign error_count = mismatches;

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      if (mismatches < PRINT_LIMIT) begin
         $display("ERROR %0t ns: %s: got %08h, expected %08h", $realtime, what, got, want);
      end
      mismatches++;
   endtask

   // bytes whose enable is set come from src, the others stay
   function automatic logic [DATA_W-1:0] merge_enabled(input logic [DATA_W-1:0] keep,
                                                       input logic [DATA_W-1:0] src,
                                                       input logic [3:0]        en);
      logic [DATA_W-1:0] res;
      res = keep;
      for (int b = 0; b < 4; b++) begin
         if (en[b]) begin
            res[8*b +: 8] = src[8*b +: 8];
         end
      end
      return res;
   endfunction

   task automatic run_page_transfer();
      int base;
      base = int'(shadow_page) * WORDS_PER_PAGE;
      if (int'(shadow_page) < PAGE_COUNT) begin
         // write into the page first, then read the (updated) page back
         if (shadow_wr_flag) begin
            for (int w = 0; w < WORDS_PER_PAGE; w++) begin
               shadow_pages[base + w] = merge_enabled(shadow_pages[base + w], shadow_data[w],
                                                      shadow_byte_en[4*w +: 4]);
            end
         end
         if (shadow_rd_flag) begin
            for (int w = 0; w < WORDS_PER_PAGE; w++) begin
               shadow_data[w] = merge_enabled(shadow_data[w], shadow_pages[base + w],
                                              shadow_byte_en[4*w +: 4]);
            end
         end
      end
      shadow_done = 1'b1;
   endtask

   task automatic apply_access(input logic is_write, input logic [OFFSET_W-1:0] off,
                               input logic [DATA_W-1:0] wd, output logic [DATA_W-1:0] rd);
      rd = '0;
      if (is_write) begin
         case (off)
            REG_CONTROL: begin
               shadow_page    = wd[PAGE_W-1:0];
               shadow_rd_flag = wd[CTL_READ_BIT];
               shadow_wr_flag = wd[CTL_WRITE_BIT];
               run_page_transfer();
            end
            REG_BYTE_EN: begin
               shadow_byte_en = wd[BE_W-1:0];
            end
            REG_STATUS: begin
               if (wd[0]) begin
                  shadow_done = 1'b0;
               end
            end
            REG_TIMING: begin
               shadow_timing = wd;
            end
            REG_DATA0, REG_DATA1, REG_DATA2, REG_DATA3: begin
               shadow_data[WORD_IW'(off - REG_DATA0)] = wd;
            end
            default: ;
         endcase
      end else begin
         case (off)
            REG_CONTROL: begin
               rd[PAGE_W-1:0]    = shadow_page;
               rd[CTL_READ_BIT]  = shadow_rd_flag;
               rd[CTL_WRITE_BIT] = shadow_wr_flag;
            end
            REG_BYTE_EN: begin
               rd[BE_W-1:0] = shadow_byte_en;
            end
            REG_STATUS: begin
               rd[0] = shadow_done;
            end
            REG_TIMING: begin
               rd = shadow_timing;
            end
            REG_DATA0, REG_DATA1, REG_DATA2, REG_DATA3: begin
               rd = shadow_data[WORD_IW'(off - REG_DATA0)];
            end
            default: ;
         endcase
      end
   endtask

   always @(posedge clock) begin
      logic [DATA_W-1:0] rd;
      logic [DATA_W-1:0] want;
      if (reset) begin
         for (int i = 0; i < STORE_WORDS; i++) begin
            shadow_pages[i] = '0;
         end
         for (int w = 0; w < WORDS_PER_PAGE; w++) begin
            shadow_data[w] = '0;
         end
         shadow_byte_en = BE_RESET;
         shadow_timing  = TIMING_RESET;
         shadow_page    = '0;
         shadow_rd_flag = 1'b0;
         shadow_wr_flag = 1'b0;
         shadow_done    = 1'b0;
         expected_read_data.delete();
         requests_seen  <= 0;
         responses_seen <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_access(req_func, req_word_offset, req_write_data, rd);
            expected_read_data.push_back(rd);
            requests_seen <= requests_seen + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_read_data.size() == 0) begin
               report_mismatch("response with no transaction outstanding", rsp_read_data, '0);
            end else begin
               want = expected_read_data.pop_front();
               responses_seen <= responses_seen + 1;
               if (rsp_read_data !== want) begin
                  report_mismatch("read_data", rsp_read_data, want);
               end
            end
         end
      end
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives register transactions into the OTP page controller: a directed
// pass over reset values, page writes and reads, byte masks, status and
// unmapped offsets, then random page transfer sequences mixed with random
// accesses. Sender bursts, receiver stalls and one long response hold-off
// load the handshake; the checker module does all prediction and compare.
// ----------------------------------------------------------------------------

module testbench;
   import opc_pkg::*;

   localparam int  ITEM_TARGET  = 1450;
   localparam int  LONG_HOLD    = 400;
   localparam int  IDLE_LIMIT   = 6000;
   localparam int  DRAIN_CYCLES = 20;
   localparam logic FN_READ     = 1'b0;
   localparam logic FN_WRITE    = 1'b1;
   localparam logic [OFFSET_W-1:0] OFF_UNMAPPED_LO  = 6'd4;
   localparam logic [OFFSET_W-1:0] OFF_UNMAPPED_MID = 6'd31;
   localparam logic [OFFSET_W-1:0] OFF_UNMAPPED_HI  = 6'd36;
   localparam logic [OFFSET_W-1:0] OFF_TOP          = 6'd63;

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_func        = 1'b0;
   logic [OFFSET_W-1:0] req_word_offset = '0;
   logic [DATA_W-1:0]   req_write_data  = '0;
   logic                rsp_stall       = 1'b0;
   logic                req_stall;
   logic                rsp_valid;
   logic [DATA_W-1:0]   rsp_read_data;

   int error_count;
   int pending;
   int items_sent    = 0;
   int burst_left    = 1;
   int hold_requests = 0;
   int idle_cycles   = 0;

   otp_page_controller_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_word_offset (req_word_offset),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data)
   );

   otp_page_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_word_offset (req_word_offset),
      .req_write_data  (req_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_data   (rsp_read_data),
      .error_count     (error_count),
      .pending         (pending)
   );

   initial begin
      forever begin
         #10 clock = ~clock;
      end
   end

   function automatic logic [DATA_W-1:0] rand_word();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return $urandom & $urandom;
         3: return $urandom | $urandom;
         default: return $urandom;
      endcase
   endfunction

   // unused control bits get random junk
   function automatic logic [DATA_W-1:0] control_word(input logic [PAGE_W-1:0] page,
                                                      input logic rd, input logic wr);
      logic [DATA_W-1:0] w;
      w                = $urandom;
      w[PAGE_W-1:0]    = page;
      w[CTL_READ_BIT]  = rd;
      w[CTL_WRITE_BIT] = wr;
      return w;
   endfunction

   // offer one transaction and hold it until accepted; gaps come between bursts
   task automatic issue(input logic func, input logic [OFFSET_W-1:0] off,
                        input logic [DATA_W-1:0] data);
      req_valid       <= 1'b1;
      req_func        <= func;
      req_word_offset <= off;
      req_write_data  <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // receiver stall pattern, plus a long hold-off whenever one is requested
   initial begin
      int holds_served;
      int mode;
      holds_served = 0;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(8, 60)) begin
            @(posedge clock);
            if (hold_requests != holds_served) begin
               holds_served++;
               rsp_stall <= 1'b1;
               repeat (LONG_HOLD - 1) @(posedge clock);
            end else begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= 1'($urandom_range(0, 1));
                  default: rsp_stall <= ($urandom_range(0, 3) != 0);
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int                  kind;
      logic [PAGE_W-1:0]   page;
      logic [OFFSET_W-1:0] off;
      logic [DATA_W-1:0]   be_word;
      bit                  held;
      bit                  paused;
      held   = 1'b0;
      paused = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset values, including an unmapped read at the top of the map
      issue(FN_READ, REG_CONTROL, '0);
      issue(FN_READ, REG_BYTE_EN, '0);
      issue(FN_READ, REG_STATUS, '0);
      issue(FN_READ, REG_TIMING, '0);
      issue(FN_READ, REG_DATA0, '0);
      issue(FN_READ, OFF_TOP, '1);
      // full write of the last page, junk in unused control bits
      issue(FN_WRITE, REG_DATA0, '1);
      issue(FN_WRITE, REG_DATA2, 32'hA5A5_A5A5);
      issue(FN_WRITE, REG_DATA3, 32'h5A5A_5A5A);
      issue(FN_WRITE, REG_CONTROL, 32'hFFFF_BFFF);
      issue(FN_READ, REG_CONTROL, '0);
      // masked read back; upper byte-enable bits are dropped
      issue(FN_WRITE, REG_BYTE_EN, 32'hFFFF_5A3C);
      issue(FN_WRITE, REG_DATA0, '0);
      issue(FN_WRITE, REG_CONTROL, 32'h0000_41FF);
      issue(FN_READ, REG_DATA0, '0);
      issue(FN_READ, REG_DATA2, '0);
      // done: writing 0 keeps it, writing 1 clears it
      issue(FN_READ, REG_STATUS, '0);
      issue(FN_WRITE, REG_STATUS, 32'hFFFF_FFFE);
      issue(FN_READ, REG_STATUS, '0);
      issue(FN_WRITE, REG_STATUS, '1);
      issue(FN_WRITE, REG_TIMING, '1);
      issue(FN_READ, REG_TIMING, '0);
      issue(FN_WRITE, OFF_UNMAPPED_LO, '1);
      issue(FN_WRITE, OFF_UNMAPPED_HI, '1);
      issue(FN_READ, OFF_UNMAPPED_MID, '0);
      // both flags with nothing enabled
      issue(FN_WRITE, REG_BYTE_EN, '0);
      issue(FN_WRITE, REG_CONTROL, 32'h0000_C000);
      wait_drained();

      while (items_sent < ITEM_TARGET) begin
         if (!held && items_sent >= 500) begin
            held = 1'b1;
            hold_requests <= hold_requests + 1;
         end
         if (!paused && items_sent >= 1000) begin
            paused = 1'b1;
            wait_drained();
         end
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            // page transfer sequence: load data, maybe mask, run, check back
            repeat ($urandom_range(0, 4)) begin
               issue(FN_WRITE, OFFSET_W'(REG_DATA0 + $urandom_range(0, 3)), rand_word());
            end
            if ($urandom_range(0, 2) == 0) begin
               be_word = $urandom;
               if ($urandom_range(0, 1) == 0) begin
                  be_word[BE_W-1:0] = BE_RESET;
               end
               issue(FN_WRITE, REG_BYTE_EN, be_word);
            end
            case ($urandom_range(0, 3))
               0, 1: page = PAGE_W'($urandom_range(0, 7));
               2: page = PAGE_W'(PAGE_COUNT - 1 - $urandom_range(0, 3));
               default: page = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
            endcase
            issue(FN_WRITE, REG_CONTROL,
                  control_word(page, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            if ($urandom_range(0, 1) == 0) begin
               issue(FN_READ, REG_STATUS, rand_word());
            end
            if ($urandom_range(0, 2) == 0) begin
               issue(FN_WRITE, REG_STATUS, rand_word());
            end
            repeat ($urandom_range(0, 4)) begin
               issue(FN_READ, OFFSET_W'(REG_DATA0 + $urandom_range(0, 3)), rand_word());
            end
         end else if (kind <= 8) begin
            case ($urandom_range(0, 7))
               0: off = REG_CONTROL;
               1: off = REG_BYTE_EN;
               2: off = REG_STATUS;
               3: off = REG_TIMING;
               default: off = OFFSET_W'(REG_DATA0 + $urandom_range(0, 3));
            endcase
            issue(1'($urandom_range(0, 1)), off, rand_word());
         end else begin
            issue(1'($urandom_range(0, 1)), OFFSET_W'($urandom_range(0, 63)), rand_word());
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
